/* sv/rp4_pkg.sv */
package rp4_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int TRIG_FRAC_BITS = 16;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
	localparam int PROD_W         = COORD_WIDTH + TRIG_W;
	localparam int SUM_W          = PROD_W + 1;

	localparam int PLANE_W = 3;
	localparam int ANGLE_W = 18;

	// register index on the config port (address bit 2)
	localparam logic REG_PLANE = 1'b0;
	localparam logic REG_ANGLE = 1'b1;

	localparam logic [PLANE_W-1:0] PLANE_XY = 3'd0;
	localparam logic [PLANE_W-1:0] PLANE_YZ = 3'd1;
	localparam logic [PLANE_W-1:0] PLANE_XZ = 3'd2;
	localparam logic [PLANE_W-1:0] PLANE_XU = 3'd3;
	localparam logic [PLANE_W-1:0] PLANE_YU = 3'd4;
	localparam logic [PLANE_W-1:0] PLANE_ZU = 3'd5;

	// angle reduction and degree to radian scaling
	localparam int TURN_UNITS    = 92160;
	localparam int QUARTER_UNITS = 23040;
	localparam int QUARTER_W     = $clog2(QUARTER_UNITS);
	localparam longint PI_Q32    = 64'd13493037705;
	localparam int DIV_D         = 184320;
	// pi split into whole multiples of the divisor and a remainder
	localparam int PI_INT        = int'(PI_Q32 / DIV_D);
	localparam int PI_REM        = int'(PI_Q32 % DIV_D);
	// divisor is 45 << 12; divide by 45 through ceil(2^25 / 45)
	localparam int FRAC_SH       = 12;
	localparam int RECIP_45      = 745655;
	localparam int RECIP_SH      = 25;
	localparam int RECIP_W       = 20;
	localparam int REM_W         = 31;
	localparam int NUM_W         = REM_W - FRAC_SH;
	localparam int RP_W          = NUM_W + RECIP_W;
	localparam int Q2_W          = 14;

	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CORDIC_W     = 33;
	localparam int CORDIC_FRAC  = 30;
	localparam longint CORDIC_GAIN_Q30 = 64'd652032874;
	localparam int ROUND_SH     = CORDIC_FRAC - TRIG_FRAC_BITS;

	localparam logic [30:0] ATAN_Q30 [CORDIC_STEPS] = '{
		31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
		31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149,
		31'd1048575,   31'd524287,    31'd262143,    31'd131071,    31'd65535,
		31'd32767,     31'd16383,     31'd8191,      31'd4095,      31'd2047,
		31'd1023,      31'd511,       31'd255,       31'd127,       31'd63,
		31'd31,        31'd15,        31'd8,         31'd4,         31'd2
	};

	typedef enum logic [2:0] {
		TS_IDLE,
		TS_WRAP,
		TS_QUAD,
		TS_MUL,
		TS_DIV,
		TS_LOAD,
		TS_ROT,
		TS_DONE
	} trig_state_t;

	typedef struct packed {
		logic                     busy;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	typedef struct packed {
		logic               vld;
		logic [PLANE_W-1:0] plane;
	} pipe_ctl_t;

endpackage

/* sv/rotate_point_4d_plane.sv */
// rotate_point_4d_plane: rotates points (x, y, z, u, w) in one coordinate plane.
// command channel: a point is taken at a rising edge with start high and busy low.
// result channel: done is high for exactly one cycle with x_out..w_out valid;
// the receiver must take it then, there is no back-pressure.
// a new point can be started in every cycle in which busy is low, before earlier points
// are done: a four-stage pipeline (operand select, multiply, add, round and saturate),
// one valid bit per stage.
// config port: plane at address 0, angle_deg at address 4 (1/256 degree units).
// writing angle_deg starts the sine/cosine unit, which holds busy high through angle
// reduction, a reciprocal multiply that turns degrees into radians, loading the rotator,
// the cordic rotation and storing the result.
// configuration is to be written only with the pipeline empty.
// after reset: plane XY, angle 0 (cos 1.0, sin 0), pipeline empty, busy low.
module rotate_point_4d_plane import rp4_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic signed [COORD_WIDTH-1:0] z_in,
	input  logic signed [COORD_WIDTH-1:0] u_in,
	input  logic signed [COORD_WIDTH-1:0] w_in,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic signed [COORD_WIDTH-1:0] z_out,
	output logic signed [COORD_WIDTH-1:0] u_out,
	output logic signed [COORD_WIDTH-1:0] w_out
);

	logic [PLANE_W-1:0]        plane_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic                      wr;
	logic                      angle_ld;
	logic                      accept;
	trig_t                     trig;

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign angle_ld = wr && (paddr[2] == REG_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
			angle_q <= '0;
		end else if (wr) begin
			if (paddr[2] == REG_PLANE)
				plane_q <= pwdata[PLANE_W-1:0];
			else
				angle_q <= pwdata[ANGLE_W-1:0];
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PLANE: prdata = 32'(plane_q);
			default:   prdata = 32'(angle_q);
		endcase
	end

	rp4_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (angle_ld),
		.angle  ($signed(pwdata[ANGLE_W-1:0])),
		.trig   (trig)
	);

	assign busy   = trig.busy;
	assign accept = start && !trig.busy;

	rp4_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.plane   (plane_q),
		.cos_v   (trig.cos_v),
		.sin_v   (trig.sin_v),
		.x_in    (x_in),
		.y_in    (y_in),
		.z_in    (z_in),
		.u_in    (u_in),
		.w_in    (w_in),
		.out_vld (done),
		.x_out   (x_out),
		.y_out   (y_out),
		.z_out   (z_out),
		.u_out   (u_out),
		.w_out   (w_out)
	);

endmodule

/* sv/rp4_trig.sv */
module rp4_trig import rp4_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ld,
	input  logic signed [ANGLE_W-1:0] angle,
	output trig_t                     trig
);

	localparam logic signed [CORDIC_W-1:0] RND =
		(ROUND_SH > 0) ? CORDIC_W'(64'd1 << (ROUND_SH - 1)) : '0;
	localparam logic signed [CORDIC_W-1:0] ONE_C = CORDIC_W'(64'd1 << TRIG_FRAC_BITS);

	trig_state_t state_q, state_nx;

	logic signed [ANGLE_W-1:0]  a_q;
	logic [1:0]                 quad_q;
	logic [CORDIC_W-1:0]        zk_q;
	logic [NUM_W-1:0]           num_q;
	logic [Q2_W-1:0]            q2_q;
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic [STEP_W-1:0]          rot_cnt_q;
	logic signed [TRIG_W-1:0]   cos_q, sin_q;

	logic signed [CORDIC_W-1:0] dx, dy, at;
	logic signed [TRIG_W-1:0]   c_r, s_r;
	logic                       busy;

	function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W-1:0] r;
		r = (v + RND) >>> ROUND_SH;
		if (r < 0)
			r = '0;
		if (r > ONE_C)
			r = ONE_C;
		return r[TRIG_W-1:0];
	endfunction

	assign dx = y_q >>> rot_cnt_q;
	assign dy = x_q >>> rot_cnt_q;
	assign at = $signed(CORDIC_W'(ATAN_Q30[rot_cnt_q]));

	assign c_r = trig_round(x_q);
	assign s_r = trig_round(y_q);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			TS_IDLE: if (ld) state_nx = TS_WRAP;
			TS_WRAP: begin
				if (!(a_q < 0) && !(a_q >= ANGLE_W'(TURN_UNITS)))
					state_nx = TS_QUAD;
			end
			TS_QUAD: if (a_q < ANGLE_W'(QUARTER_UNITS)) state_nx = TS_MUL;
			TS_MUL:  state_nx = TS_DIV;
			TS_DIV:  state_nx = TS_LOAD;
			TS_LOAD: state_nx = TS_ROT;
			TS_ROT:  if (rot_cnt_q == STEP_W'(CORDIC_STEPS - 1)) state_nx = TS_DONE;
			TS_DONE: state_nx = TS_IDLE;
			default: state_nx = TS_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			TS_IDLE: busy = 1'b0;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			cos_q   <= TRIG_W'(64'd1 << TRIG_FRAC_BITS);
			sin_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == TS_DONE) begin
				case (quad_q)
					2'd0: begin cos_q <= c_r;  sin_q <= s_r;  end
					2'd1: begin cos_q <= -s_r; sin_q <= c_r;  end
					2'd2: begin cos_q <= -c_r; sin_q <= -s_r; end
					default: begin cos_q <= s_r; sin_q <= -c_r; end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			TS_IDLE: begin
				a_q    <= angle;
				quad_q <= '0;
			end
			TS_WRAP: begin
				if (a_q < 0)
					a_q <= a_q + ANGLE_W'(TURN_UNITS);
				else if (a_q >= ANGLE_W'(TURN_UNITS))
					a_q <= a_q - ANGLE_W'(TURN_UNITS);
			end
			TS_QUAD: begin
				if (a_q >= ANGLE_W'(QUARTER_UNITS)) begin
					a_q    <= a_q - ANGLE_W'(QUARTER_UNITS);
					quad_q <= quad_q + 2'd1;
				end
			end
			TS_MUL: begin
				// t*pi/184320 = t*PI_INT + (t*PI_REM + half) / 184320
				zk_q  <= CORDIC_W'(a_q[QUARTER_W-1:0]) * CORDIC_W'(PI_INT);
				num_q <= NUM_W'((REM_W'(a_q[QUARTER_W-1:0]) * REM_W'(PI_REM) +
					REM_W'(DIV_D / 2)) >> FRAC_SH);
			end
			TS_DIV: begin
				q2_q <= Q2_W'((RP_W'(num_q) * RP_W'(RECIP_45)) >> RECIP_SH);
			end
			TS_LOAD: begin
				x_q       <= CORDIC_W'(CORDIC_GAIN_Q30);
				y_q       <= '0;
				z_q       <= $signed(zk_q + CORDIC_W'(q2_q));
				rot_cnt_q <= '0;
			end
			TS_ROT: begin
				if (!z_q[CORDIC_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				rot_cnt_q <= rot_cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign trig.busy  = busy;
	assign trig.cos_v = cos_q;
	assign trig.sin_v = sin_q;

endmodule

/* sv/rp4_pipe.sv */
module rp4_pipe import rp4_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [PLANE_W-1:0]            plane,
	input  logic signed [TRIG_W-1:0]      cos_v,
	input  logic signed [TRIG_W-1:0]      sin_v,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic signed [COORD_WIDTH-1:0] z_in,
	input  logic signed [COORD_WIDTH-1:0] u_in,
	input  logic signed [COORD_WIDTH-1:0] w_in,
	output logic                          out_vld,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic signed [COORD_WIDTH-1:0] z_out,
	output logic signed [COORD_WIDTH-1:0] u_out,
	output logic signed [COORD_WIDTH-1:0] w_out
);

	localparam int CW = COORD_WIDTH;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (TRIG_FRAC_BITS - 1));
	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-TRIG_FRAC_BITS-CW:0] hi;
		hi = v[SUM_W-1:TRIG_FRAC_BITS+CW-1];
		if (&hi || ~|hi)
			return v[TRIG_FRAC_BITS+CW-1:TRIG_FRAC_BITS];
		else if (v[SUM_W-1])
			return MINV;
		else
			return MAXV;
	endfunction

	logic signed [CW-1:0]     p, q;
	logic                     flip;

	pipe_ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [CW-1:0]     p_s1, q_s1;
	logic signed [TRIG_W-1:0] ca_s1, cb_s1, cc_s1, cd_s1;
	logic signed [CW-1:0]     x_s1, y_s1, z_s1, u_s1, w_s1;

	logic signed [PROD_W-1:0] m0_s2, m1_s2, m2_s2, m3_s2;
	logic signed [CW-1:0]     x_s2, y_s2, z_s2, u_s2, w_s2;

	logic signed [SUM_W-1:0]  sa_s3, sb_s3;
	logic signed [CW-1:0]     x_s3, y_s3, z_s3, u_s3, w_s3;

	logic signed [CW-1:0]     ra, rb;
	logic signed [CW-1:0]     xn, yn, zn, un;
	logic signed [CW-1:0]     x_s4, y_s4, z_s4, u_s4, w_s4;

	// pick the two coordinates of the plane; flip marks the planes with -s on the first row
	always_comb begin
		p    = x_in;
		q    = y_in;
		flip = 1'b0;
		case (plane)
			PLANE_XY: begin p = x_in; q = y_in; flip = 1'b0; end
			PLANE_YZ: begin p = y_in; q = z_in; flip = 1'b0; end
			PLANE_XZ: begin p = x_in; q = z_in; flip = 1'b1; end
			PLANE_XU: begin p = x_in; q = u_in; flip = 1'b0; end
			PLANE_YU: begin p = y_in; q = u_in; flip = 1'b1; end
			PLANE_ZU: begin p = z_in; q = u_in; flip = 1'b1; end
			default: begin p = x_in; q = y_in; flip = 1'b0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= '{vld: in_vld, plane: plane};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= p;
		q_s1  <= q;
		ca_s1 <= cos_v;
		cb_s1 <= flip ? -sin_v : sin_v;
		cc_s1 <= flip ? sin_v : -sin_v;
		cd_s1 <= cos_v;
		x_s1  <= x_in;
		y_s1  <= y_in;
		z_s1  <= z_in;
		u_s1  <= u_in;
		w_s1  <= w_in;

		m0_s2 <= p_s1 * ca_s1;
		m1_s2 <= q_s1 * cb_s1;
		m2_s2 <= p_s1 * cc_s1;
		m3_s2 <= q_s1 * cd_s1;
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		z_s2  <= z_s1;
		u_s2  <= u_s1;
		w_s2  <= w_s1;

		// ties round up: add half before the floor shift
		sa_s3 <= SUM_W'(m0_s2) + SUM_W'(m1_s2) + HALF;
		sb_s3 <= SUM_W'(m2_s2) + SUM_W'(m3_s2) + HALF;
		x_s3  <= x_s2;
		y_s3  <= y_s2;
		z_s3  <= z_s2;
		u_s3  <= u_s2;
		w_s3  <= w_s2;

		x_s4  <= xn;
		y_s4  <= yn;
		z_s4  <= zn;
		u_s4  <= un;
		w_s4  <= w_s3;
	end

	assign ra = sat(sa_s3);
	assign rb = sat(sb_s3);

	always_comb begin
		xn = x_s3;
		yn = y_s3;
		zn = z_s3;
		un = u_s3;
		case (ctl_s3.plane)
			PLANE_XY: begin xn = ra; yn = rb; end
			PLANE_YZ: begin yn = ra; zn = rb; end
			PLANE_XZ: begin xn = ra; zn = rb; end
			PLANE_XU: begin xn = ra; un = rb; end
			PLANE_YU: begin yn = ra; un = rb; end
			PLANE_ZU: begin zn = ra; un = rb; end
			default: ;
		endcase
	end

	assign out_vld = ctl_s4.vld;
	assign x_out   = x_s4;
	assign y_out   = y_s4;
	assign z_out   = z_s4;
	assign u_out   = u_s4;
	assign w_out   = w_s4;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import rp4_pkg::*;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t u;
		coord_t w;
	} point_t;

	typedef enum logic {WORK_POINT, WORK_WRITE} work_kind_t;

	typedef struct {
		work_kind_t  kind;
		logic        reg_sel;
		logic [31:0] data;
		point_t      pt;
	} work_t;

	typedef enum logic [1:0] {DRV_RUN, DRV_SETUP, DRV_ACCESS} drv_state_t;

	localparam logic [PLANE_W-1:0] PLANE_SPARE_6 = 3'd6;
	localparam logic [PLANE_W-1:0] PLANE_SPARE_7 = 3'd7;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// angle units are 1/256 degree
	localparam int     FULL_TURN    = 92160;
	localparam int     QUARTER_TURN = 23040;
	localparam int     DEG          = 256;
	localparam longint PI_FX_Q32    = 64'd13493037705;
	localparam longint GAIN_FX_Q30  = 64'd652032874;
	localparam int     SIN_FRAC     = 16;
	localparam int     ROT_STEPS    = 30;
	localparam longint ARCTAN_Q30 [ROT_STEPS] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535,
		32767, 16383, 8191, 4095, 2047,
		1023, 511, 255, 127, 63,
		31, 15, 8, 4, 2
	};

	localparam int RANDOM_POINTS = 1030;
	localparam int DRAIN_CYCLES  = 10;
	localparam int LIMIT_CYCLES  = 200000;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start   = 1'b0;
	logic        busy;
	coord_t      x_in    = '0;
	coord_t      y_in    = '0;
	coord_t      z_in    = '0;
	coord_t      u_in    = '0;
	coord_t      w_in    = '0;
	logic        done;
	coord_t      x_out;
	coord_t      y_out;
	coord_t      z_out;
	coord_t      u_out;
	coord_t      w_out;

	work_t  work_q[$];
	point_t rotated_q[$];

	// model of the block's configuration and trig registers
	logic [PLANE_W-1:0] plane_cfg = PLANE_XY;
	longint             cos_q     = longint'(1) <<< SIN_FRAC;
	longint             sin_q     = 0;

	drv_state_t drv_state = DRV_RUN;
	point_t     held;
	int         burst_left = 1;
	int         gap_left   = 0;
	int         mismatches = 0;
	int         cycles     = 0;

	rotate_point_4d_plane i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.x_in    (x_in),
		.y_in    (y_in),
		.z_in    (z_in),
		.u_in    (u_in),
		.w_in    (w_in),
		.done    (done),
		.x_out   (x_out),
		.y_out   (y_out),
		.z_out   (z_out),
		.u_out   (u_out),
		.w_out   (w_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cordic result to SIN_FRAC bits, clamped to [0, 1.0]
	function automatic longint trig_clamp(longint v);
		longint r;
		r = (v + (longint'(1) <<< (29 - SIN_FRAC))) >>> (30 - SIN_FRAC);
		if (r < 0)
			r = 0;
		if (r > (longint'(1) <<< SIN_FRAC))
			r = longint'(1) <<< SIN_FRAC;
		return r;
	endfunction

	function automatic void set_rotation_angle(logic [ANGLE_W-1:0] raw);
		longint a, quad, t, ang, cx, cy, dx, dy, c, s;
		int     i;
		a = longint'($signed(raw)) % FULL_TURN;
		if (a < 0)
			a += FULL_TURN;
		quad = a / QUARTER_TURN;
		t    = a - quad * QUARTER_TURN;
		ang  = (t * PI_FX_Q32 + 92160) / 184320;
		cx   = GAIN_FX_Q30;
		cy   = 0;
		for (i = 0; i < ROT_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (ang >= 0) begin
				cx  -= dx;
				cy  += dy;
				ang -= ARCTAN_Q30[i];
			end else begin
				cx  += dx;
				cy  -= dy;
				ang += ARCTAN_Q30[i];
			end
		end
		c = trig_clamp(cx);
		s = trig_clamp(cy);
		// fold the first-quadrant pair back into the full circle
		case (quad)
			0: begin
				cos_q = c;
				sin_q = s;
			end
			1: begin
				cos_q = -s;
				sin_q = c;
			end
			2: begin
				cos_q = -c;
				sin_q = -s;
			end
			default: begin
				cos_q = s;
				sin_q = -c;
			end
		endcase
	endfunction

	// round half up of (p*cp + q*cq) / 2^SIN_FRAC, saturated
	function automatic coord_t mix(longint p, longint cp, longint q, longint cq);
		longint acc, hi, lo;
		hi  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		lo  = -hi - 1;
		acc = (p * cp + q * cq + (longint'(1) <<< (SIN_FRAC - 1))) >>> SIN_FRAC;
		if (acc > hi)
			acc = hi;
		if (acc < lo)
			acc = lo;
		return coord_t'(acc);
	endfunction

	function automatic point_t rotate_point(point_t p);
		point_t r;
		r = p;
		case (plane_cfg)
			PLANE_XY: begin
				r.x = mix(p.x, cos_q, p.y, sin_q);
				r.y = mix(p.x, -sin_q, p.y, cos_q);
			end
			PLANE_YZ: begin
				r.y = mix(p.y, cos_q, p.z, sin_q);
				r.z = mix(p.y, -sin_q, p.z, cos_q);
			end
			PLANE_XZ: begin
				r.x = mix(p.x, cos_q, p.z, -sin_q);
				r.z = mix(p.x, sin_q, p.z, cos_q);
			end
			PLANE_XU: begin
				r.x = mix(p.x, cos_q, p.u, sin_q);
				r.u = mix(p.x, -sin_q, p.u, cos_q);
			end
			PLANE_YU: begin
				r.y = mix(p.y, cos_q, p.u, -sin_q);
				r.u = mix(p.y, sin_q, p.u, cos_q);
			end
			PLANE_ZU: begin
				r.z = mix(p.z, cos_q, p.u, -sin_q);
				r.u = mix(p.z, sin_q, p.u, cos_q);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_point(coord_t x, coord_t y, coord_t z, coord_t u, coord_t w);
		work_t e;
		e.kind    = WORK_POINT;
		e.reg_sel = REG_PLANE;
		e.data    = '0;
		e.pt      = '{x, y, z, u, w};
		work_q.push_back(e);
	endfunction

	function automatic void add_write(logic reg_sel, logic [31:0] data);
		work_t e;
		e.kind    = WORK_WRITE;
		e.reg_sel = reg_sel;
		e.data    = data;
		e.pt      = '{'0, '0, '0, '0, '0};
		work_q.push_back(e);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 11))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3, 4, 5: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return 32'(QUARTER_TURN * (int'($urandom_range(0, 8)) - 4));
			1: return 32'(int'($urandom_range(0, 262143)) - 131072);
			default: return 32'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
		endcase
	endfunction

	function automatic logic [31:0] rand_plane();
		if ($urandom_range(0, 9) == 0)
			return 32'($urandom_range(PLANE_SPARE_6, PLANE_SPARE_7));
		return 32'($urandom_range(PLANE_XY, PLANE_ZU));
	endfunction

	function automatic int new_burst();
		return $urandom_range(1, 40);
	endfunction

	function automatic int new_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(1, 8);
	endfunction

	// sender: points in bursts, register writes only once every result is back
	always @(posedge clk or negedge arst_n) begin
		work_t e;
		logic  go;
		if (!arst_n) begin
			start      <= 1'b0;
			psel       <= 1'b0;
			penable    <= 1'b0;
			pwrite     <= 1'b0;
			drv_state  = DRV_RUN;
			burst_left = new_burst();
			gap_left   = 0;
		end else begin
			case (drv_state)
				DRV_RUN: begin
					go = start;
					if (start && !busy) begin
						rotated_q.push_back(rotate_point(held));
						go = 1'b0;
					end
					if (!go) begin
						if (gap_left > 0) begin
							gap_left--;
						end else if (work_q.size() > 0) begin
							if (work_q[0].kind == WORK_POINT) begin
								e    = work_q.pop_front();
								held = e.pt;
								x_in <= e.pt.x;
								y_in <= e.pt.y;
								z_in <= e.pt.z;
								u_in <= e.pt.u;
								w_in <= e.pt.w;
								go   = 1'b1;
								burst_left--;
								if (burst_left == 0) begin
									burst_left = new_burst();
									gap_left   = new_gap();
								end
							end else if (rotated_q.size() == 0 && !busy) begin
								psel      <= 1'b1;
								pwrite    <= 1'b1;
								paddr     <= {work_q[0].reg_sel, 2'b00};
								pwdata    <= work_q[0].data;
								drv_state = DRV_SETUP;
							end
						end
						start <= go;
					end
				end
				DRV_SETUP: begin
					penable   <= 1'b1;
					drv_state = DRV_ACCESS;
				end
				DRV_ACCESS: begin
					if (pready) begin
						e = work_q.pop_front();
						if (e.reg_sel == REG_PLANE)
							plane_cfg = e.data[PLANE_W-1:0];
						else
							set_rotation_angle(e.data[ANGLE_W-1:0]);
						psel      <= 1'b0;
						penable   <= 1'b0;
						pwrite    <= 1'b0;
						drv_state = DRV_RUN;
					end
				end
				default: drv_state = DRV_RUN;
			endcase
		end
	end

	function automatic void check_coord(string name, coord_t want, coord_t got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h (%0d) actual %h (%0d)",
				$time, name, want, want, got, got);
		end
	endfunction

	// each result beat is taken at the edge that ends its cycle
	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (arst_n && done) begin
			if (rotated_q.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with no point pending, actual %h %h %h %h %h",
					$time, x_out, y_out, z_out, u_out, w_out);
			end else begin
				want = rotated_q.pop_front();
				check_coord("x_out", want.x, x_out);
				check_coord("y_out", want.y, y_out);
				check_coord("z_out", want.z, z_out);
				check_coord("u_out", want.u, u_out);
				check_coord("w_out", want.w, w_out);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("rotate_point_4d_plane regression: fail");
			$finish;
		end
	end

	initial begin
		int left, n, k, mode;

		// reset settings: identity in the xy plane
		add_point(COORD_MAX, COORD_MIN, '0, -1, 1);
		add_point(COORD_MIN, COORD_MAX, 1, '0, -1);
		add_point(32'sh0001_0000, 32'sh0002_8000, -32'sh0003_0000, 32'sh7fff_0000, COORD_MIN);

		// 45 degrees, equal large inputs overflow
		add_write(REG_PLANE, 32'(PLANE_XY));
		add_write(REG_ANGLE, 32'(45 * DEG));
		add_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		add_point(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		add_point(COORD_MAX, COORD_MIN, 1, -1, '0);

		// quadrant boundaries, cosine near zero after rounding
		add_write(REG_PLANE, 32'(PLANE_YZ));
		add_write(REG_ANGLE, 32'(90 * DEG));
		add_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000);
		add_point(COORD_MIN, COORD_MIN, COORD_MAX, -1, 1);

		// half turn negates, so the most negative value saturates
		add_write(REG_PLANE, 32'(PLANE_XZ));
		add_write(REG_ANGLE, 32'(180 * DEG));
		add_point(COORD_MIN, COORD_MAX, COORD_MIN, '0, COORD_MIN);
		add_point(-1, -1, -1, -1, -1);

		add_write(REG_PLANE, 32'(PLANE_XU));
		add_write(REG_ANGLE, 32'(270 * DEG));
		add_point(COORD_MIN, 7, 9, COORD_MAX, 3);
		add_point(32'sh0000_8000, '0, '0, -32'sh0000_8000, '0);

		add_write(REG_PLANE, 32'(PLANE_YU));
		add_write(REG_ANGLE, 32'(-30 * DEG));
		add_point(1, COORD_MAX, 2, COORD_MIN, 3);
		add_point(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ffff, 32'sh0abc_def0, 32'sh7000_0000);

		// a full turn reduces to zero
		add_write(REG_PLANE, 32'(PLANE_ZU));
		add_write(REG_ANGLE, 32'(FULL_TURN));
		add_point(4, 5, COORD_MAX, COORD_MIN, 6);
		add_point(-32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000, 32'sh0002_0000, 1);

		// unused plane codes leave the point alone
		add_write(REG_PLANE, 32'(PLANE_SPARE_6));
		add_write(REG_ANGLE, 32'(-FULL_TURN));
		add_point(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, '0);
		add_point(32'sh0f0f_0f0f, -32'sh0f0f_0f0f, 1, -1, 2);
		add_write(REG_PLANE, 32'(PLANE_SPARE_7));
		add_point(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, -1);

		// angle register beyond one turn in both directions
		add_write(REG_PLANE, 32'(PLANE_XY));
		add_write(REG_ANGLE, 32'(131071));
		add_point(32'sh4000_0000, -32'sh4000_0000, 0, 0, 0);
		add_write(REG_ANGLE, 32'(-131072));
		add_point(32'sh4000_0000, 32'sh4000_0000, 0, 0, 0);

		left = RANDOM_POINTS;
		while (left > 0) begin
			mode = $urandom_range(0, 3);
			if (mode == 0) begin
				add_write(REG_PLANE, rand_plane());
			end else if (mode == 1) begin
				add_write(REG_ANGLE, rand_angle());
			end else if (mode == 2) begin
				add_write(REG_PLANE, rand_plane());
				add_write(REG_ANGLE, rand_angle());
			end else begin
				add_write(REG_ANGLE, rand_angle());
				add_write(REG_PLANE, rand_plane());
			end
			n = $urandom_range(20, 80);
			if (n > left)
				n = left;
			for (k = 0; k < n; k++)
				add_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
			left -= n;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (work_q.size() != 0 || start || rotated_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("rotate_point_4d_plane regression: pass");
		else
			$display("rotate_point_4d_plane regression: fail");
		$finish;
	end

endmodule

/* rotate_point_4d_plane.f */
sv/rp4_pkg.sv
sv/rp4_trig.sv
sv/rp4_pipe.sv
sv/rotate_point_4d_plane.sv
test/tb_top.sv
